/* hw/rtl/wnps_pkg.sv */
// package for the weighted nearest pose search block
// holds shared types, state encodings, widths and reset values; no dependencies
package wnps_pkg;

    localparam int POSE_DEPTH_DEF  = 256;
    localparam int TRACK_DEPTH_DEF = 8;

    localparam int DIFF_W = 33;   // signed difference of two q16.16 values
    localparam int SQ_W   = 66;   // sum of three squared differences
    localparam int ROOT_W = 36;   // partial remainder of root and divide
    localparam int RES_W  = 40;   // alu result, root or quotient
    localparam int DIST_W = 34;   // distance value used by the cost
    localparam int NUM_W  = 40;   // trajectory distance sum
    localparam int DEN_W  = 7;    // trajectory point count
    localparam int CNT_W  = 6;    // alu step counter
    localparam int COST_W = 48;
    localparam int PROD_W = 50;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    localparam int POSE_W = 256;  // packed pose entry
    localparam int TRK_W  = 96;   // packed trajectory entry

    localparam logic [15:0] POS_WEIGHT_RST = 16'd256;
    localparam logic [15:0] VEL_WEIGHT_RST = 16'd256;
    localparam logic [15:0] TRK_WEIGHT_RST = 16'd256;
    localparam logic [31:0] MIN_TIME_RST   = 32'd32768;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_POS_WEIGHT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_WEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRK_WEIGHT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TIME   = 8'd3;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_POSE  = 2'd1,
        KIND_TRACK = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef enum logic {
        OP_DIST = 1'b0,
        OP_DIV  = 1'b1
    } t_alu_op;

    typedef enum logic [1:0] {
        U_IDLE,
        U_SQ,
        U_ROOT,
        U_DIV
    } t_alu_state;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_RD,
        S_CHECK,
        S_PWAIT,
        S_PMUL,
        S_PADD,
        S_VWAIT,
        S_VMUL,
        S_VADD,
        S_TRD,
        S_TCHK,
        S_TWAIT,
        S_DIV,
        S_DWAIT,
        S_TMUL,
        S_TADD,
        S_CMP,
        S_DONE
    } t_seq_state;

    typedef struct packed {
        logic                     start;
        t_alu_op                  op;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        logic [NUM_W-1:0]         num;
        logic [DEN_W-1:0]         den;
    } t_alu_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [RES_W-1:0] result;
    } t_alu_rsp;

endpackage

/* hw/rtl/wnps_ram.sv */
// generic single-write single-read ram with registered read data
// no dependencies
module wnps_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

/* hw/rtl/wnps_alu.sv */
// shared iterative unit: distance (shift-add squares, digit root) and small divide
// depends on wnps_pkg
module wnps_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wnps_pkg::t_alu_req i_req,
    output wnps_pkg::t_alu_rsp o_rsp
);
    import wnps_pkg::*;

    t_alu_state r_state, n_state;
    logic [DIFF_W-1:0] r_mag [3];
    logic [DIFF_W-1:0] r_mp;
    logic [SQ_W-1:0]   r_mc;
    logic [SQ_W-1:0]   r_rad;
    logic [ROOT_W-1:0] r_rem;
    logic [RES_W-1:0]  r_root;
    logic [DEN_W-1:0]  r_den;
    logic [1:0]        r_comp;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;

    logic [DIFF_W-1:0] w_mag [3];
    logic [ROOT_W-1:0] w_rem_sh, w_trial, w_drem;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
        abs_diff = d[DIFF_W-1] ? DIFF_W'(0) - d : d;
    endfunction

    always_comb begin
        w_mag[0] = abs_diff(i_req.dx);
        w_mag[1] = abs_diff(i_req.dy);
        w_mag[2] = abs_diff(i_req.dz);
        w_rem_sh = {r_rem[ROOT_W-3:0], r_rad[SQ_W-1 -: 2]};
        w_trial  = {r_root[ROOT_W-3:0], 2'b01};
        w_drem   = {r_rem[ROOT_W-2:0], r_rad[SQ_W-1]};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    n_state = (i_req.op == OP_DIV) ? U_DIV : U_SQ;
                end
            end
            U_SQ: begin
                if (r_cnt == CNT_W'(DIFF_W - 1) && r_comp == 2'd2) begin
                    n_state = U_ROOT;
                end
            end
            U_ROOT: begin
                if (r_cnt == CNT_W'(DIFF_W - 1)) begin
                    n_state = U_IDLE;
                end
            end
            U_DIV: begin
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_state = U_IDLE;
                end
            end
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state != U_IDLE) && (n_state == U_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            U_IDLE: begin
                // result holds until the next request
                if (i_req.start) begin
                    r_cnt  <= '0;
                    r_comp <= '0;
                    r_rem  <= '0;
                    r_root <= '0;
                    r_den  <= i_req.den;
                    r_mag  <= w_mag;
                    r_mp   <= w_mag[0];
                    r_mc   <= SQ_W'(w_mag[0]);
                    r_rad  <= (i_req.op == OP_DIV) ? {i_req.num, {(SQ_W-NUM_W){1'b0}}} : '0;
                end
            end
            U_SQ: begin
                if (r_mp[0]) begin
                    r_rad <= r_rad + r_mc;
                end
                if (r_cnt == CNT_W'(DIFF_W - 1)) begin
                    r_cnt  <= '0;
                    r_comp <= r_comp + 2'd1;
                    if (r_comp != 2'd2) begin
                        r_mp <= r_mag[r_comp + 2'd1];
                        r_mc <= SQ_W'(r_mag[r_comp + 2'd1]);
                    end
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    r_mp  <= r_mp >> 1;
                    r_mc  <= r_mc << 1;
                end
            end
            U_ROOT: begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_rad <= r_rad << 2;
                if (w_rem_sh >= w_trial) begin
                    r_rem  <= w_rem_sh - w_trial;
                    r_root <= {r_root[RES_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_rem_sh;
                    r_root <= {r_root[RES_W-2:0], 1'b0};
                end
            end
            U_DIV: begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_rad <= r_rad << 1;
                if (w_drem >= ROOT_W'(r_den)) begin
                    r_rem  <= w_drem - ROOT_W'(r_den);
                    r_root <= {r_root[RES_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_drem;
                    r_root <= {r_root[RES_W-2:0], 1'b0};
                end
            end
            default: r_cnt <= '0;
        endcase
    end

    assign o_rsp.busy   = (r_state != U_IDLE);
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_root;
endmodule

/* hw/rtl/weighted_nearest_pose_search.sv */
// weighted nearest pose search: pose store, trajectory store, query sequencer
// clear and appends are taken without a stall; a query walks every stored pose
//   and skips same-animation poses that lie inside the min time window
// one transaction at a time: input stalled until the query result is loaded
// the shared distance/divide unit works one bit or root digit per cycle
// reset (synchronous, active low): counts zeroed, weights 1.0, min time 0.5
module weighted_nearest_pose_search #(
    parameter int POSE_DEPTH  = wnps_pkg::POSE_DEPTH_DEF,
    parameter int TRACK_DEPTH = wnps_pkg::TRACK_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_kind,
    input  logic [15:0]                        i_anim_id,
    input  logic [15:0]                        i_frame_number,
    input  logic [31:0]                        i_time_stamp,
    input  logic signed [31:0]                 i_pos_x,
    input  logic signed [31:0]                 i_pos_y,
    input  logic signed [31:0]                 i_pos_z,
    input  logic signed [31:0]                 i_vel_x,
    input  logic signed [31:0]                 i_vel_y,
    input  logic signed [31:0]                 i_vel_z,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_found,
    output logic [7:0]                         o_entry_index,
    output logic [15:0]                        o_best_anim_id,
    output logic [15:0]                        o_best_frame,
    output logic [47:0]                        o_best_cost,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [wnps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wnps_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import wnps_pkg::*;

    localparam int PAW = (POSE_DEPTH > 1) ? $clog2(POSE_DEPTH) : 1;
    localparam int PCW = $clog2(POSE_DEPTH + 1);
    localparam int TAW = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
    localparam int TCW = $clog2(TRACK_DEPTH + 1);

    // configuration registers
    logic [15:0] r_pos_w, r_vel_w, r_trk_w;
    logic [31:0] r_min_time;

    // sequencer
    t_seq_state r_state, n_state;
    logic [PCW-1:0] r_pose_count, r_idx;
    logic [TCW-1:0] r_track_count, r_k;

    // query transaction
    logic [15:0]        r_q_anim;
    logic [31:0]        r_q_time;
    logic signed [31:0] r_qp [3];
    logic signed [31:0] r_qv [3];

    // current pose, cost accumulation and best so far
    logic [POSE_W-1:0] r_pose;
    logic [COST_W-1:0] r_cost, r_best_cost;
    logic [PROD_W-1:0] r_prod;
    logic [NUM_W-1:0]  r_tsum;
    logic              r_have;
    logic [PCW-1:0]    r_best_idx;
    logic [15:0]       r_best_anim, r_best_frame;

    // result register
    logic              r_out_valid, r_found;
    logic [7:0]        r_out_idx;
    logic [15:0]       r_out_anim, r_out_frame;
    logic [COST_W-1:0] r_out_cost;

    logic w_in_acc, w_cfg_acc, w_skip, w_out_free;
    logic [POSE_W-1:0] w_pose_rd, w_pose_wr;
    logic [TRK_W-1:0]  w_trk_rd;
    logic [31:0]       w_td;
    logic [15:0]       w_mul_w;
    logic [PROD_W:0]   w_sum;
    logic [PCW+7:0]    w_idx_ext;
    t_alu_req          w_req;
    t_alu_rsp          w_rsp;

    // pose entry fields, packed msb first
    logic [15:0] w_rd_anim, w_rd_frame;
    logic [31:0] w_rd_time;
    logic signed [31:0] w_rd_p [3];
    logic signed [31:0] w_lp [3];
    logic signed [31:0] w_lv [3];
    logic signed [31:0] w_tp [3];

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);

    assign w_pose_wr = {i_anim_id, i_frame_number, i_time_stamp, i_pos_x, i_pos_y, i_pos_z,
                        i_vel_x, i_vel_y, i_vel_z};
    assign w_rd_anim  = w_pose_rd[255:240];
    assign w_rd_frame = w_pose_rd[239:224];
    assign w_rd_time  = w_pose_rd[223:192];
    assign w_rd_p[0]  = w_pose_rd[191:160];
    assign w_rd_p[1]  = w_pose_rd[159:128];
    assign w_rd_p[2]  = w_pose_rd[127:96];
    assign w_lp[0]    = r_pose[191:160];
    assign w_lp[1]    = r_pose[159:128];
    assign w_lp[2]    = r_pose[127:96];
    assign w_lv[0]    = r_pose[95:64];
    assign w_lv[1]    = r_pose[63:32];
    assign w_lv[2]    = r_pose[31:0];
    assign w_tp[0]    = w_trk_rd[95:64];
    assign w_tp[1]    = w_trk_rd[63:32];
    assign w_tp[2]    = w_trk_rd[31:0];

    wnps_ram #(.WIDTH(POSE_W), .DEPTH(POSE_DEPTH), .ADDR_W(PAW)) u_pose_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_acc && t_kind'(i_kind) == KIND_POSE &&
                    r_pose_count < PCW'(POSE_DEPTH)),
        .i_wr_addr (r_pose_count[PAW-1:0]),
        .i_wr_data (w_pose_wr),
        .i_rd_addr (r_idx[PAW-1:0]),
        .o_rd_data (w_pose_rd)
    );

    wnps_ram #(.WIDTH(TRK_W), .DEPTH(TRACK_DEPTH), .ADDR_W(TAW)) u_track_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_acc && t_kind'(i_kind) == KIND_TRACK &&
                    r_track_count < TCW'(TRACK_DEPTH)),
        .i_wr_addr (r_track_count[TAW-1:0]),
        .i_wr_data ({i_pos_x, i_pos_y, i_pos_z}),
        .i_rd_addr (r_k[TAW-1:0]),
        .o_rd_data (w_trk_rd)
    );

    wnps_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // same-animation time window check on the freshly read pose
    assign w_td   = (w_rd_time > r_q_time) ? w_rd_time - r_q_time : r_q_time - w_rd_time;
    assign w_skip = (w_rd_anim == r_q_anim) && (w_td < r_min_time);

    // one weight multiplier, selected by the cost term in flight
    always_comb begin
        case (r_state)
            S_PMUL:  w_mul_w = r_pos_w;
            S_VMUL:  w_mul_w = r_vel_w;
            default: w_mul_w = r_trk_w;
        endcase
    end
    assign w_sum = (PROD_W+1)'(r_cost) + (PROD_W+1)'(r_prod);

    // next state and unit requests
    always_comb begin
        n_state   = r_state;
        w_req     = '0;
        w_req.op  = OP_DIST;
        w_req.num = r_tsum;
        w_req.den = DEN_W'(r_track_count);
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && t_kind'(i_kind) == KIND_QUERY) begin
                    n_state = S_START;
                end
            end
            S_START: n_state = (r_idx >= r_pose_count) ? S_DONE : S_RD;
            S_RD:    n_state = S_CHECK;
            S_CHECK: begin
                if (w_skip) begin
                    n_state = S_START;
                end else begin
                    w_req.start = 1'b1;
                    w_req.dx = {w_rd_p[0][31], w_rd_p[0]} - {r_qp[0][31], r_qp[0]};
                    w_req.dy = {w_rd_p[1][31], w_rd_p[1]} - {r_qp[1][31], r_qp[1]};
                    w_req.dz = {w_rd_p[2][31], w_rd_p[2]} - {r_qp[2][31], r_qp[2]};
                    n_state = S_PWAIT;
                end
            end
            S_PWAIT: if (w_rsp.done) n_state = S_PMUL;
            S_PMUL:  n_state = S_PADD;
            S_PADD: begin
                w_req.start = 1'b1;
                w_req.dx = {w_lv[0][31], w_lv[0]} - {r_qv[0][31], r_qv[0]};
                w_req.dy = {w_lv[1][31], w_lv[1]} - {r_qv[1][31], r_qv[1]};
                w_req.dz = {w_lv[2][31], w_lv[2]} - {r_qv[2][31], r_qv[2]};
                n_state = S_VWAIT;
            end
            S_VWAIT: if (w_rsp.done) n_state = S_VMUL;
            S_VMUL:  n_state = S_VADD;
            S_VADD:  n_state = (r_track_count == '0) ? S_CMP : S_TRD;
            S_TRD:   n_state = S_TCHK;
            S_TCHK: begin
                w_req.start = 1'b1;
                w_req.dx = {w_tp[0][31], w_tp[0]} - {w_lp[0][31], w_lp[0]};
                w_req.dy = {w_tp[1][31], w_tp[1]} - {w_lp[1][31], w_lp[1]};
                w_req.dz = {w_tp[2][31], w_tp[2]} - {w_lp[2][31], w_lp[2]};
                n_state = S_TWAIT;
            end
            S_TWAIT: begin
                if (w_rsp.done) begin
                    n_state = (r_k + TCW'(1) == r_track_count) ? S_DIV : S_TRD;
                end
            end
            S_DIV: begin
                w_req.start = 1'b1;
                w_req.op    = OP_DIV;
                n_state     = S_DWAIT;
            end
            S_DWAIT: if (w_rsp.done) n_state = S_TMUL;
            S_TMUL:  n_state = S_TADD;
            S_TADD:  n_state = S_CMP;
            S_CMP:   n_state = S_START;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pose_count  <= '0;
            r_track_count <= '0;
            r_out_valid   <= 1'b0;
            r_pos_w       <= POS_WEIGHT_RST;
            r_vel_w       <= VEL_WEIGHT_RST;
            r_trk_w       <= TRK_WEIGHT_RST;
            r_min_time    <= MIN_TIME_RST;
        end else begin
            r_state <= n_state;
            if (w_cfg_acc) begin
                case (i_cfg_index)
                    REG_POS_WEIGHT: r_pos_w    <= i_cfg_data[15:0];
                    REG_VEL_WEIGHT: r_vel_w    <= i_cfg_data[15:0];
                    REG_TRK_WEIGHT: r_trk_w    <= i_cfg_data[15:0];
                    REG_MIN_TIME:   r_min_time <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                case (t_kind'(i_kind))
                    KIND_CLEAR: r_pose_count <= '0;
                    KIND_POSE: begin
                        if (r_pose_count < PCW'(POSE_DEPTH)) begin
                            r_pose_count <= r_pose_count + PCW'(1);
                        end
                    end
                    KIND_TRACK: begin
                        if (r_track_count < TCW'(TRACK_DEPTH)) begin
                            r_track_count <= r_track_count + TCW'(1);
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid   <= 1'b1;
                r_track_count <= '0;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx    <= '0;
                r_have   <= 1'b0;
                r_q_anim <= i_anim_id;
                r_q_time <= i_time_stamp;
                r_qp     <= '{i_pos_x, i_pos_y, i_pos_z};
                r_qv     <= '{i_vel_x, i_vel_y, i_vel_z};
            end
            S_CHECK: begin
                r_pose <= w_pose_rd;
                r_cost <= '0;
                if (w_skip) begin
                    r_idx <= r_idx + PCW'(1);
                end
            end
            S_PMUL, S_VMUL, S_TMUL: begin
                r_prod <= PROD_W'(w_rsp.result[DIST_W-1:0] * w_mul_w);
            end
            S_PADD, S_VADD, S_TADD: begin
                r_cost <= (w_sum > (PROD_W+1)'(COST_MAX)) ? COST_MAX : w_sum[COST_W-1:0];
                r_k    <= '0;
                r_tsum <= '0;
            end
            S_TWAIT: begin
                if (w_rsp.done) begin
                    r_tsum <= r_tsum + NUM_W'(w_rsp.result[DIST_W-1:0]);
                    r_k    <= r_k + TCW'(1);
                end
            end
            S_CMP: begin
                // strict compare keeps the lowest index among equal costs
                if (!r_have || r_cost < r_best_cost) begin
                    r_have       <= 1'b1;
                    r_best_cost  <= r_cost;
                    r_best_idx   <= r_idx;
                    r_best_anim  <= r_pose[255:240];
                    r_best_frame <= r_pose[239:224];
                end
                r_idx <= r_idx + PCW'(1);
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_found     <= r_have;
                    r_out_idx   <= r_have ? w_idx_ext[7:0] : 8'd0;
                    r_out_anim  <= r_have ? r_best_anim : 16'd0;
                    r_out_frame <= r_have ? r_best_frame : 16'd0;
                    r_out_cost  <= r_have ? r_best_cost : '0;
                end
            end
            default: ;
        endcase
    end

    assign w_idx_ext = {8'd0, r_best_idx};

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_entry_index  = r_out_idx;
    assign o_best_anim_id = r_out_anim;
    assign o_best_frame   = r_out_frame;
    assign o_best_cost    = r_out_cost;

    // an empty result carries all-zero fields
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_best_cost == '0 && o_entry_index == 8'd0)
        else $error("empty result with nonzero fields");

    // counts never pass their store depth
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pose_count <= PCW'(POSE_DEPTH) && r_track_count <= TCW'(TRACK_DEPTH))
        else $error("store count beyond depth");

    // the shared unit is only started when free
    a_alu_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_rsp.busy)
        else $error("unit started while busy");

    // a finished query clears the trajectory store
    a_track_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && w_out_free |=> r_track_count == '0)
        else $error("trajectory store not cleared");
endmodule

/* sim/wnps_checker.sv */
// checker for the weighted nearest pose search block
// watches the input, result and configuration channels, predicts query results
// and compares them; depends on wnps_pkg only
module wnps_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [1:0]                     i_kind,
    input  logic [15:0]                    i_anim_id,
    input  logic [15:0]                    i_frame_number,
    input  logic [31:0]                    i_time_stamp,
    input  logic [31:0]                    i_pos_x,
    input  logic [31:0]                    i_pos_y,
    input  logic [31:0]                    i_pos_z,
    input  logic [31:0]                    i_vel_x,
    input  logic [31:0]                    i_vel_y,
    input  logic [31:0]                    i_vel_z,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_found,
    input  logic [7:0]                     i_entry_index,
    input  logic [15:0]                    i_best_anim_id,
    input  logic [15:0]                    i_best_frame,
    input  logic [47:0]                    i_best_cost,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [wnps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wnps_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import wnps_pkg::*;

    localparam int POSES  = POSE_DEPTH_DEF;
    localparam int TRACKS = TRACK_DEPTH_DEF;

    typedef struct {
        logic [15:0] anim;
        logic [15:0] frame;
        logic [31:0] tstamp;
        logic [31:0] p [3];
        logic [31:0] v [3];
    } t_pose;

    typedef struct {
        logic        found;
        logic [7:0]  index;
        logic [15:0] anim;
        logic [15:0] frame;
        logic [47:0] cost;
    } t_match;

    t_pose       pose_store [POSES];
    logic [31:0] track_store [TRACKS][3];
    int          n_poses, n_tracks;
    logic [15:0] w_pos, w_vel, w_trk;
    logic [31:0] min_time;
    t_match      match_q [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = match_q.size();

    // floor of euclidean length of the difference of two signed q16.16 triples
    function automatic logic [33:0] span(input logic [31:0] a [3], input logic [31:0] b [3]);
        logic [69:0] sum, t, r;
        logic signed [32:0] d;
        logic [69:0] m;
        sum = '0;
        for (int k = 0; k < 3; k++) begin
            d = $signed({a[k][31], a[k]}) - $signed({b[k][31], b[k]});
            m = d < 0 ? 70'(-d) : 70'(d);
            sum = sum + m * m;
        end
        r = '0;
        for (int bit_n = 33; bit_n >= 0; bit_n--) begin
            t = r | (70'd1 << bit_n);
            if (t * t <= sum) r = t;
        end
        return r[33:0];
    endfunction

    function automatic logic [47:0] sat_sum(input logic [47:0] a, input logic [49:0] b);
        logic [50:0] s;
        s = 51'(a) + 51'(b);
        return s > 51'(COST_MAX) ? COST_MAX : s[47:0];
    endfunction

    function automatic t_match search(input logic [15:0] anim, input logic [31:0] tstamp,
                                      input logic [31:0] qp [3], input logic [31:0] qv [3]);
        t_match      res;
        logic [47:0] c;
        logic [37:0] tsum;
        logic [31:0] td;
        res = '{found: 1'b0, index: '0, anim: '0, frame: '0, cost: '0};
        for (int i = 0; i < n_poses; i++) begin
            if (pose_store[i].anim == anim) begin
                td = pose_store[i].tstamp > tstamp ? pose_store[i].tstamp - tstamp
                                                   : tstamp - pose_store[i].tstamp;
                if (td < min_time) continue;
            end
            c = sat_sum('0, span(pose_store[i].p, qp) * w_pos);
            c = sat_sum(c, span(pose_store[i].v, qv) * w_vel);
            tsum = '0;
            if (n_tracks > 0) begin
                for (int k = 0; k < n_tracks; k++) tsum += span(track_store[k], pose_store[i].p);
                tsum = tsum / n_tracks;
            end
            c = sat_sum(c, tsum[33:0] * w_trk);
            if (!res.found || c < res.cost) begin
                res = '{found: 1'b1, index: i[7:0], anim: pose_store[i].anim,
                        frame: pose_store[i].frame, cost: c};
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        logic [31:0] qp [3];
        logic [31:0] qv [3];
        t_match      want;
        if (!i_rst_n) begin
            n_poses  = 0;
            n_tracks = 0;
            w_pos    = POS_WEIGHT_RST;
            w_vel    = VEL_WEIGHT_RST;
            w_trk    = TRK_WEIGHT_RST;
            min_time = MIN_TIME_RST;
            match_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_POS_WEIGHT: w_pos = i_cfg_data[15:0];
                    REG_VEL_WEIGHT: w_vel = i_cfg_data[15:0];
                    REG_TRK_WEIGHT: w_trk = i_cfg_data[15:0];
                    REG_MIN_TIME:   min_time = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                qp = '{i_pos_x, i_pos_y, i_pos_z};
                qv = '{i_vel_x, i_vel_y, i_vel_z};
                case (t_kind'(i_kind))
                    KIND_CLEAR: n_poses = 0;
                    KIND_POSE: if (n_poses < POSES) begin
                        pose_store[n_poses] = '{anim: i_anim_id, frame: i_frame_number,
                                                tstamp: i_time_stamp, p: qp, v: qv};
                        n_poses++;
                    end
                    KIND_TRACK: if (n_tracks < TRACKS) begin
                        track_store[n_tracks] = qp;
                        n_tracks++;
                    end
                    default: begin
                        match_q.insert(match_q.size(), search(i_anim_id, i_time_stamp, qp, qv));
                        n_tracks = 0;
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (match_q.size() == 0) begin
                    $error("result transaction with no query waiting");
                    fails++;
                end else begin
                    want = match_q.pop_front();
                    if (i_found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, i_found);
                        fails++;
                    end
                    if (i_entry_index !== want.index) begin
                        $error("entry_index: expected %0d, got %0d", want.index, i_entry_index);
                        fails++;
                    end
                    if (i_best_anim_id !== want.anim) begin
                        $error("best_anim_id: expected %0d, got %0d", want.anim, i_best_anim_id);
                        fails++;
                    end
                    if (i_best_frame !== want.frame) begin
                        $error("best_frame: expected %0d, got %0d", want.frame, i_best_frame);
                        fails++;
                    end
                    if (i_best_cost !== want.cost) begin
                        $error("best_cost: expected %h, got %h", want.cost, i_best_cost);
                        fails++;
                    end
                end
            end
        end
    end

    initial fails = 0;

endmodule

/* sim/tb_weighted_nearest_pose_search.sv */
// testbench top for the weighted nearest pose search block
// drives directed and random transactions and gives the verdict; depends on
// wnps_pkg, weighted_nearest_pose_search and wnps_checker
module tb_weighted_nearest_pose_search;
    import wnps_pkg::*;

    // the watchdog limit sits well above a full 256-pose query with 8 trajectory points
    localparam int WATCHDOG_LIMIT = 2000000;
    localparam int ITEM_TARGET    = 700;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  kind = '0;
    logic [15:0] anim_id = '0, frame_number = '0;
    logic [31:0] time_stamp = '0;
    logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0, vel_x = '0, vel_y = '0, vel_z = '0;
    logic        out_valid, out_stall = 1'b1;
    logic        found;
    logic [7:0]  entry_index;
    logic [15:0] best_anim_id, best_frame;
    logic [47:0] best_cost;
    logic        cfg_valid = 1'b0, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    int          fail_count, pending;
    int          items_sent = 0;
    int          idle_cycles = 0;
    bit          no_gaps = 1'b0;     // stretches with no idling on either side
    bit          long_hold = 1'b0;   // receiver pressure request

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    weighted_nearest_pose_search dut (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_anim_id(anim_id), .i_frame_number(frame_number),
        .i_time_stamp(time_stamp),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_vel_x(vel_x), .i_vel_y(vel_y), .i_vel_z(vel_z),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_found(found), .o_entry_index(entry_index), .o_best_anim_id(best_anim_id),
        .o_best_frame(best_frame), .o_best_cost(best_cost),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    wnps_checker chk (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_kind(kind), .i_anim_id(anim_id), .i_frame_number(frame_number),
        .i_time_stamp(time_stamp),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_vel_x(vel_x), .i_vel_y(vel_y), .i_vel_z(vel_z),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_found(found), .i_entry_index(entry_index), .i_best_anim_id(best_anim_id),
        .i_best_frame(best_frame), .i_best_cost(best_cost),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog: any accepted transaction on any channel resets the count
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_weighted_nearest_pose_search: FAIL");
            $finish;
        end
    end

    // result side: random stall per transaction, one long hold when asked
    initial begin
        int gap;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 3);
            if (long_hold) begin
                gap = 400;
                long_hold = 1'b0;
            end
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!out_valid);
            @(negedge i_clk);
        end
    end

    // mix of extremes, small signed values and full random words
    function automatic logic [31:0] coord();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        endcase
    endfunction

    // one input transaction; always entered and left at a falling edge
    task automatic send(input t_kind k, input logic [15:0] a, input logic [15:0] f,
                        input logic [31:0] t, input logic [31:0] px, input logic [31:0] py,
                        input logic [31:0] pz, input logic [31:0] vx, input logic [31:0] vy,
                        input logic [31:0] vz);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        kind <= k; anim_id <= a; frame_number <= f; time_stamp <= t;
        pos_x <= px; pos_y <= py; pos_z <= pz; vel_x <= vx; vel_y <= vy; vel_z <= vz;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_rand(input t_kind k);
        send(k, 16'($urandom_range(0, 3)), 16'($urandom), $urandom_range(0, 32'h0004_0000),
             coord(), coord(), coord(), coord(), coord(), coord());
    endtask

    // register write, only once every query result is back and the block is quiet
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic rand_weights();
        logic [15:0] pick [4];
        pick = '{16'd0, 16'hFFFF, 16'd256, 16'($urandom)};
        write_reg(REG_POS_WEIGHT, pick[$urandom_range(0, 3)]);
        write_reg(REG_VEL_WEIGHT, pick[$urandom_range(0, 3)]);
        write_reg(REG_TRK_WEIGHT, pick[$urandom_range(0, 3)]);
        case ($urandom_range(0, 3))
            0: write_reg(REG_MIN_TIME, 32'd0);
            1: write_reg(REG_MIN_TIME, 32'hFFFF_FFFF);
            default: write_reg(REG_MIN_TIME, $urandom_range(0, 32'h0003_0000));
        endcase
    endtask

    initial begin
        int n;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty store query gives no match
        send(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // extreme poses and a same-animation pose inside the time window
        send(KIND_POSE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send(KIND_POSE, 16'd1, 16'd7, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send(KIND_POSE, 16'd2, 16'd3, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
        // equal cost twin: the lower index must win
        send(KIND_POSE, 16'd2, 16'd4, 32'h0001_0000, 0, 0, 0, 0, 0, 0);
        send(KIND_TRACK, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
        send(KIND_QUERY, 16'd1, 0, 32'h0001_4000, 0, 0, 0, 0, 0, 0);
        // a same-animation pose whose time gap equals a huge window is kept (strict compare)
        write_reg(REG_MIN_TIME, 32'hFFFF_FFFF);
        send(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send(KIND_POSE, 16'd5, 16'd1, 32'h0, 32'h100, 0, 0, 0, 0, 0);
        send(KIND_QUERY, 16'd5, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        // trajectory store overfilled, heaviest weights to saturate the cost
        write_reg(REG_POS_WEIGHT, 16'hFFFF);
        write_reg(REG_VEL_WEIGHT, 16'hFFFF);
        write_reg(REG_TRK_WEIGHT, 16'hFFFF);
        write_reg(REG_MIN_TIME, 32'd0);
        write_reg(8'd4, 32'hDEAD_BEEF);    // unknown index, ignored
        write_reg(8'hFF, 32'h1234_5678);
        send(KIND_POSE, 16'd6, 16'd9, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        for (int k = 0; k < 9; k++)
            send(KIND_TRACK, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
        send(KIND_QUERY, 16'd0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        // clear leaves no pose to report
        send(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        // random phases of well-formed sequences, with some noise
        n = 0;
        while (items_sent < ITEM_TARGET) begin
            rand_weights();
            no_gaps = ($urandom_range(0, 4) == 0);
            if (n == 3) long_hold = 1'b1;
            if (n == 6) begin
                // fill the pose store past capacity, then one plain query
                send(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
                for (int k = 0; k < 260; k++) send_rand(KIND_POSE);
                send_rand(KIND_QUERY);
            end
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 2) == 0) send(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
                repeat ($urandom_range(0, 6)) send_rand(KIND_POSE);
                repeat ($urandom_range(0, 9)) send_rand(KIND_TRACK);
                if ($urandom_range(0, 5) == 0) send_rand(t_kind'($urandom_range(0, 3)));
                send_rand(KIND_QUERY);
            end
            n++;
        end
        in_valid <= 1'b0;
        no_gaps = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_weighted_nearest_pose_search: PASS");
        else
            $display("tb_weighted_nearest_pose_search: FAIL");
        $finish;
    end

endmodule

/* weighted_nearest_pose_search.f */
hw/rtl/wnps_pkg.sv
hw/rtl/wnps_ram.sv
hw/rtl/wnps_alu.sv
hw/rtl/weighted_nearest_pose_search.sv
sim/wnps_checker.sv
sim/tb_weighted_nearest_pose_search.sv
